[hdl/rmcil_pkg.sv]
// shared types and constants of the row match column interpolating lookup unit
package rmcil_pkg;

  localparam int VAL_W      = 32;
  localparam int AGE_W      = 8;
  localparam int ROWSLOT_W  = 7;
  localparam int COLSLOT_W  = 4;
  localparam int S_TDATA_W  = 56;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 32;
  localparam int M_TUSER_W  = 3;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int ROWS_CFG_W = 8;
  localparam int COLS_CFG_W = 5;
  localparam int DIV_CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_ROW_KEY    = 2'd0,
    OP_BREAKPOINT = 2'd1,
    OP_ENTRY      = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_NO_AGE = 2'd2
  } stat_t;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS_IN_USE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ROW_RD,
    S_ROW_CHK,
    S_BP_RD,
    S_BP_CHK,
    S_SEL,
    S_Y1_RD,
    S_Y1_CAP,
    S_Y2_RD,
    S_Y2_CAP,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic write;
    logic capture;
    logic start;
    logic row_chk;
    logic bp_chk;
    logic sel;
    logic y1_cap;
    logic y2_cap;
    logic prep;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic row_match;
    logic row_last;
    logic bp_last;
    logic direct;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[hdl/rmcil_ctrl.sv]
// lookup sequencer state machine
module rmcil_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [1:0]         in_op,
  input  rmcil_pkg::sts_t    sts,
  output rmcil_pkg::cmd_t    cmd,
  output logic               ready
);

  rmcil_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmcil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    unique case (state)
      rmcil_pkg::S_IDLE: begin
        ready = 1'b1;
        if (in_fire) begin
          if (in_op == rmcil_pkg::OP_LOOKUP) begin
            cmd.capture = 1'b1;
            state_next  = rmcil_pkg::S_START;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      rmcil_pkg::S_START: begin
        cmd.start  = 1'b1;
        state_next = sts.empty ? rmcil_pkg::S_FIN : rmcil_pkg::S_ROW_RD;
      end
      rmcil_pkg::S_ROW_RD: state_next = rmcil_pkg::S_ROW_CHK;
      rmcil_pkg::S_ROW_CHK: begin
        cmd.row_chk = 1'b1;
        if (sts.row_match)     state_next = rmcil_pkg::S_BP_RD;
        else if (sts.row_last) state_next = rmcil_pkg::S_FIN;
        else                   state_next = rmcil_pkg::S_ROW_RD;
      end
      rmcil_pkg::S_BP_RD: state_next = rmcil_pkg::S_BP_CHK;
      rmcil_pkg::S_BP_CHK: begin
        cmd.bp_chk = 1'b1;
        state_next = sts.bp_last ? rmcil_pkg::S_SEL : rmcil_pkg::S_BP_RD;
      end
      rmcil_pkg::S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = rmcil_pkg::S_Y1_RD;
      end
      rmcil_pkg::S_Y1_RD: state_next = rmcil_pkg::S_Y1_CAP;
      rmcil_pkg::S_Y1_CAP: begin
        cmd.y1_cap = 1'b1;
        state_next = sts.direct ? rmcil_pkg::S_FIN : rmcil_pkg::S_Y2_RD;
      end
      rmcil_pkg::S_Y2_RD: state_next = rmcil_pkg::S_Y2_CAP;
      rmcil_pkg::S_Y2_CAP: begin
        cmd.y2_cap = 1'b1;
        state_next = rmcil_pkg::S_PREP;
      end
      rmcil_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = rmcil_pkg::S_MUL;
      end
      rmcil_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = rmcil_pkg::S_DIV;
      end
      rmcil_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = rmcil_pkg::S_FIN;
      end
      rmcil_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rmcil_pkg::S_IDLE;
        end
      end
      default: state_next = rmcil_pkg::S_IDLE;
    endcase
  end

endmodule

[hdl/rmcil_dp.sv]
// datapath: config registers, key/breakpoint/entry memories, multiply, divide, output register
module rmcil_dp #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmcil_pkg::cmd_t                     cmd,
  output rmcil_pkg::sts_t                     sts,
  input  logic                                cfg_we,
  input  logic [rmcil_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rmcil_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [1:0]                          in_op,
  input  logic [rmcil_pkg::ROWSLOT_W-1:0]     in_row_slot,
  input  logic [rmcil_pkg::COLSLOT_W-1:0]     in_col_slot,
  input  logic [rmcil_pkg::AGE_W-1:0]         in_age,
  input  logic signed [rmcil_pkg::VAL_W-1:0]  in_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rmcil_pkg::VAL_W-1:0]  out_result,
  output logic [1:0]                          out_status,
  output logic                                out_exact_hit
);

  localparam int RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW  = $clog2(MAX_COLS);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int TDEP = MAX_ROWS * MAX_COLS;
  localparam int TAW  = (TDEP > 1) ? $clog2(TDEP) : 1;
  localparam int VW   = rmcil_pkg::VAL_W;

  // memories
  logic [rmcil_pkg::AGE_W-1:0] row_keys [MAX_ROWS];
  logic signed [VW-1:0]        col_bps  [MAX_COLS];
  logic signed [VW-1:0]        tab      [TDEP];
  logic [rmcil_pkg::AGE_W-1:0] rk_q;
  logic signed [VW-1:0]        bp_q;
  logic signed [VW-1:0]        tq;

  logic [rmcil_pkg::ROWS_CFG_W-1:0] rows_in_use;
  logic [rmcil_pkg::COLS_CFG_W-1:0] cols_in_use;
  logic [RCW-1:0] rows_lim;
  logic [CCW-1:0] cols_lim;
  logic [rmcil_pkg::AGE_W-1:0] age;
  logic signed [VW-1:0] num;
  logic [RAW-1:0] ridx;
  logic [RAW-1:0] row_sel;
  logic [CAW-1:0] cidx;
  logic [CAW-1:0] jsel;
  logic [CAW-1:0] clast;
  logic [CAW-1:0] col_pick;
  logic [TAW-1:0] taddr;
  logic jfound;
  logic hit;
  logic interp;
  logic signed [VW-1:0] bp0, bplast, xj, xjm1, prev;
  logic signed [VW-1:0] y1, y2;
  logic [1:0] code;
  logic [VW-1:0] mag, dx, span;
  logic neg;
  logic [VW-1:0] rem, low;
  logic [VW:0] trial;
  logic [rmcil_pkg::DIV_CNT_W-1:0] dcnt;
  logic direct_sel;
  logic signed [VW+1:0] sum;
  logic signed [VW:0] dy;
  logic signed [VW:0] dxw, spw;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= '0;
      cols_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rmcil_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_wdata[rmcil_pkg::ROWS_CFG_W-1:0];
        rmcil_pkg::REG_COLS_IN_USE: cols_in_use <= cfg_wdata[rmcil_pkg::COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.write && in_op == rmcil_pkg::OP_ROW_KEY && 32'(in_row_slot) < MAX_ROWS)
      row_keys[RAW'(in_row_slot)] <= in_age;
    rk_q <= row_keys[ridx];
  end

  always_ff @(posedge clk) begin
    if (cmd.write && in_op == rmcil_pkg::OP_BREAKPOINT && 32'(in_col_slot) < MAX_COLS)
      col_bps[CAW'(in_col_slot)] <= in_number;
    bp_q <= col_bps[cidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.write && in_op == rmcil_pkg::OP_ENTRY && 32'(in_row_slot) < MAX_ROWS
        && 32'(in_col_slot) < MAX_COLS)
      tab[TAW'(32'(in_row_slot) * MAX_COLS + 32'(in_col_slot))] <= in_number;
    tq <= tab[taddr];
  end

  assign clast = CAW'(cols_lim - CCW'(1));

  always_comb begin
    direct_sel = (num <= bp0) || (num >= bplast) || (xj == num);
    if (num <= bp0)        col_pick = '0;
    else if (num >= bplast) col_pick = clast;
    else if (xj == num)     col_pick = jsel;
    else                    col_pick = jsel - CAW'(1);
  end

  assign trial = {rem, low[VW-1]} - {1'b0, span};
  assign dy    = $signed({y2[VW-1], y2}) - $signed({y1[VW-1], y1});
  assign dxw   = $signed({num[VW-1], num}) - $signed({xjm1[VW-1], xjm1});
  assign spw   = $signed({xj[VW-1], xj}) - $signed({xjm1[VW-1], xjm1});
  assign sum   = neg ? ($signed({{2{y1[VW-1]}}, y1}) - $signed({2'b00, low}))
                     : ($signed({{2{y1[VW-1]}}, y1}) + $signed({2'b00, low}));

  // lookup working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      age      <= in_age;
      num      <= in_number;
      rows_lim <= (32'(rows_in_use) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_in_use);
      cols_lim <= (32'(cols_in_use) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_in_use);
    end
    if (cmd.start) begin
      ridx   <= '0;
      cidx   <= '0;
      hit    <= 1'b0;
      jfound <= 1'b0;
      jsel   <= '0;
      code   <= sts.empty ? rmcil_pkg::STAT_EMPTY : rmcil_pkg::STAT_OK;
    end
    if (cmd.row_chk) begin
      if (sts.row_match) begin
        row_sel <= ridx;
      end else begin
        ridx <= ridx + RAW'(1);
        if (sts.row_last) code <= rmcil_pkg::STAT_NO_AGE;
      end
    end
    if (cmd.bp_chk) begin
      if (cidx == '0) bp0 <= bp_q;
      if (cidx == clast) bplast <= bp_q;
      if (bp_q == num) hit <= 1'b1;
      if (cidx != '0 && !jfound && bp_q >= num) begin
        jfound <= 1'b1;
        jsel   <= cidx;
        xj     <= bp_q;
        xjm1   <= prev;
      end
      prev <= bp_q;
      cidx <= cidx + CAW'(1);
    end
    if (cmd.sel) begin
      interp <= !direct_sel;
      taddr  <= TAW'(32'(row_sel) * MAX_COLS + 32'(col_pick));
    end
    if (cmd.y1_cap) begin
      y1    <= tq;
      taddr <= TAW'(32'(row_sel) * MAX_COLS + 32'(jsel));
    end
    if (cmd.y2_cap) y2 <= tq;
    if (cmd.prep) begin
      neg  <= dy[VW];
      mag  <= dy[VW] ? VW'(-dy) : dy[VW-1:0];
      dx   <= dxw[VW-1:0];
      span <= spw[VW-1:0];
    end
    // quotient fits 32 bits, so the high product half starts as the remainder
    if (cmd.mul) begin
      {rem, low} <= mag * dx;
      dcnt       <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[VW]) rem <= trial[VW-1:0];
      else            rem <= {rem[VW-2:0], low[VW-1]};
      low  <= {low[VW-2:0], !trial[VW]};
      dcnt <= dcnt + rmcil_pkg::DIV_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= code;
      if (code != rmcil_pkg::STAT_OK) begin
        out_result    <= '0;
        out_exact_hit <= 1'b0;
      end else begin
        out_exact_hit <= hit;
        if (!interp)                               out_result <= y1;
        else if (sum > $signed(34'sh07FFFFFFF))    out_result <= 32'sh7FFFFFFF;
        else if (sum < -$signed(34'sh080000000))   out_result <= 32'sh80000000;
        else                                       out_result <= sum[VW-1:0];
      end
    end
  end

  always_comb begin
    sts.empty     = (rows_lim == '0) || (cols_lim == '0);
    sts.row_match = (rk_q == age);
    sts.row_last  = (32'(ridx) + 1) == 32'(rows_lim);
    sts.bp_last   = (cidx == clast);
    sts.direct    = !interp;
    sts.div_done  = (dcnt == '1);
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

[hdl/row_match_column_interpolating_lookup_unit.sv]
// top level of the row match column interpolating lookup unit
// usage:
//   slave stream (s_*) takes load and lookup items; tuser carries the operation
//   (row key, breakpoint, table entry, lookup). loads write their memory and give
//   no result. a lookup gives one result item on the master stream (m_*).
//   cfg_we/cfg_addr/cfg_wdata set rows_in_use (index 0) and cols_in_use (index 1)
//   while the block is idle.
// a lookup runs a row key scan with a read and a check state per row tried, a
//   breakpoint scan with a read and a check state per column, table reads, then
//   for an interpolated point a prep and a multiply state and the shift-subtract
//   divider; its time from the accepting edge to m_tvalid is set by the scans
//   of the key and breakpoint memories and the radix-2 divider.
// one lookup is in flight at a time; s_tready is high only when the sequencer
//   is idle, so loads go at one per cycle while no lookup runs.
// the result sits in an output register, so the next item is taken while it
//   waits; a stalled receiver holds the sequencer in its final state only if a
//   second result is ready before the first is taken.
// reset clears the config registers, the sequencer and m_tvalid; the memories
//   keep no reset value and read undefined until loaded.
module row_match_column_interpolating_lookup_unit #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // row_slot[6:0], col_slot[10:7], age[18:11], number[50:19], zero fill
  input  logic [rmcil_pkg::S_TDATA_W-1:0]     s_tdata,
  // operation[1:0]
  input  logic [rmcil_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // result[31:0]
  output logic [rmcil_pkg::M_TDATA_W-1:0]     m_tdata,
  // status[1:0], exact_hit[2]
  output logic [rmcil_pkg::M_TUSER_W-1:0]     m_tuser,
  input  logic                                cfg_we,
  input  logic [rmcil_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rmcil_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  rmcil_pkg::cmd_t cmd;
  rmcil_pkg::sts_t sts;
  logic in_fire;
  logic signed [rmcil_pkg::VAL_W-1:0] out_result;
  logic [1:0] out_status;
  logic out_exact_hit;

  assign in_fire = s_tvalid && s_tready;

  rmcil_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_op   (s_tuser[1:0]),
    .sts     (sts),
    .cmd     (cmd),
    .ready   (s_tready)
  );

  rmcil_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_op         (s_tuser[1:0]),
    .in_row_slot   (s_tdata[6:0]),
    .in_col_slot   (s_tdata[10:7]),
    .in_age        (s_tdata[18:11]),
    .in_number     ($signed(s_tdata[50:19])),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_result    (out_result),
    .out_status    (out_status),
    .out_exact_hit (out_exact_hit)
  );

  assign m_tdata = out_result;
  assign m_tuser = {out_exact_hit, out_status};

  // a result item only appears when the sequencer loads one
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result item without a finished lookup");

  // a failed lookup carries zero result and no exact hit
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != rmcil_pkg::STAT_OK) |-> (m_tdata == '0 && !m_tuser[2]))
    else $error("failed lookup with nonzero payload");

  // no item is taken while a lookup is in progress
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !s_tready)
    else $error("item taken during a lookup");

endmodule
